// ===== rtl/pcde_pkg.sv =====
package pcde_pkg;

  localparam logic [3:0] CMD_SET     = 4'd0;
  localparam logic [3:0] CMD_CLEAR   = 4'd1;
  localparam logic [3:0] CMD_READ    = 4'd2;
  localparam logic [3:0] CMD_HLINE   = 4'd3;
  localparam logic [3:0] CMD_VLINE   = 4'd4;
  localparam logic [3:0] CMD_BOX     = 4'd5;
  localparam logic [3:0] CMD_FILLBOX = 4'd6;
  localparam logic [3:0] CMD_FILL    = 4'd7;
  localparam logic [3:0] CMD_NOISE   = 4'd8;

  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PAINT,
    OP_CLEAR,
    OP_READ,
    OP_NOISE
  } op_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_READ,
    BK_RESP
  } bk_state_t;

  // One clipped rectangle of work; coordinates hold any index below 1024.
  typedef struct packed {
    op_t         op;
    logic        empty;
    logic        last;
    logic [9:0]  x0;
    logic [9:0]  x1;
    logic [9:0]  y0;
    logic [9:0]  y1;
    logic [23:0] colour;
    logic [23:0] light;
    logic [31:0] seed;
  } rect_t;

endpackage

// ===== rtl/pcde_fifo.sv =====
module pcde_fifo import pcde_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  rect_t push_data,
  output logic  full,
  input  logic  pop,
  output rect_t head,
  output logic  empty
);

  rect_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_data;
  end

endmodule

// ===== rtl/pcde_front.sv =====
module pcde_front import pcde_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] extent_x,
  input  logic signed [15:0] extent_y,
  input  logic [23:0]        colour,
  input  logic [23:0]        colour_light,
  input  logic [31:0]        seed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               store_ready,
  input  logic               full,
  output logic               push,
  output rect_t              push_data
);

  localparam logic signed [17:0] MW  = 18'(MAX_WIDTH);
  localparam logic signed [17:0] MH  = 18'(MAX_HEIGHT);
  localparam logic signed [17:0] BIG = 18'sh1FFFF;

  logic [6:0]         canvas_width;
  logic [6:0]         canvas_height;
  logic               busy;
  logic [1:0]         part;
  logic [3:0]         i_cmd;
  logic signed [15:0] i_x;
  logic signed [15:0] i_y;
  logic signed [15:0] i_ex;
  logic signed [15:0] i_ey;
  logic [23:0]        i_colour;
  logic [23:0]        i_light;
  logic [31:0]        i_seed;

  logic               accept;
  logic               size_ok;
  logic               raw_ok;
  logic               last_part;
  op_t                op;
  logic signed [17:0] xs, ys, exs, eys, x1s, y1s, aw, ah;
  logic signed [17:0] rx0, rx1, ry0, ry1, cx0, cx1, cy0, cy1;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && store_ready;
  assign accept    = in_valid && in_ready;
  assign push      = busy && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= 7'd64;
      canvas_height <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH_IDX:  canvas_width  <= cfg_data;
        CFG_HEIGHT_IDX: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      part <= 2'd0;
    end else if (accept) begin
      busy <= 1'b1;
      part <= 2'd0;
    end else if (push) begin
      if (last_part) busy <= 1'b0;
      else part <= part + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_cmd    <= cmd;
      i_x      <= x_pos;
      i_y      <= y_pos;
      i_ex     <= extent_x;
      i_ey     <= extent_y;
      i_colour <= colour;
      i_light  <= colour_light;
      i_seed   <= seed;
    end
  end

  always_comb begin
    xs  = 18'(i_x);
    ys  = 18'(i_y);
    exs = 18'(i_ex);
    eys = 18'(i_ey);
    x1s = xs + exs - 18'sd1;
    y1s = ys + eys - 18'sd1;
    aw  = (int'(canvas_width) > MAX_WIDTH) ? MW : 18'(canvas_width);
    ah  = (int'(canvas_height) > MAX_HEIGHT) ? MH : 18'(canvas_height);
    size_ok   = (i_ex > 16'sd0) && (i_ey > 16'sd0);
    last_part = (i_cmd == CMD_BOX && size_ok) ? (part == 2'd3) : 1'b1;
    raw_ok = 1'b1;
    op     = OP_PAINT;
    rx0 = xs;
    rx1 = xs;
    ry0 = ys;
    ry1 = ys;
    unique case (i_cmd) inside
      CMD_SET, CMD_CLEAR, CMD_READ: ;
      CMD_HLINE: begin
        rx0 = (xs < exs) ? xs : exs;
        rx1 = (xs < exs) ? exs : xs;
      end
      CMD_VLINE: begin
        ry0 = (ys < eys) ? ys : eys;
        ry1 = (ys < eys) ? eys : ys;
      end
      CMD_BOX: begin
        raw_ok = size_ok;
        case (part)
          2'd0: rx1 = x1s;
          2'd1: begin
            rx1 = x1s;
            ry0 = y1s;
            ry1 = y1s;
          end
          2'd2: ry1 = y1s;
          default: begin
            rx0 = x1s;
            rx1 = x1s;
            ry1 = y1s;
          end
        endcase
      end
      CMD_FILLBOX: begin
        raw_ok = size_ok;
        rx1 = x1s;
        ry1 = y1s;
      end
      CMD_FILL, CMD_NOISE: begin
        rx0 = 18'sd0;
        rx1 = BIG;
        ry0 = 18'sd0;
        ry1 = BIG;
      end
      default: raw_ok = 1'b0;
    endcase
    unique case (i_cmd) inside
      CMD_CLEAR: op = OP_CLEAR;
      CMD_READ:  op = OP_READ;
      CMD_NOISE: op = OP_NOISE;
      CMD_SET, CMD_HLINE, CMD_VLINE, CMD_BOX, CMD_FILLBOX, CMD_FILL: op = OP_PAINT;
      default:   op = OP_NONE;
    endcase
    cx0 = (rx0 < 18'sd0) ? 18'sd0 : rx0;
    cy0 = (ry0 < 18'sd0) ? 18'sd0 : ry0;
    cx1 = (rx1 > aw - 18'sd1) ? aw - 18'sd1 : rx1;
    cy1 = (ry1 > ah - 18'sd1) ? ah - 18'sd1 : ry1;

    push_data.op     = op;
    push_data.empty  = !raw_ok || (cx0 > cx1) || (cy0 > cy1);
    push_data.last   = last_part;
    push_data.x0     = cx0[9:0];
    push_data.x1     = cx1[9:0];
    push_data.y0     = cy0[9:0];
    push_data.y1     = cy1[9:0];
    push_data.colour = i_colour;
    push_data.light  = i_light;
    push_data.seed   = i_seed;
  end

endmodule

// ===== rtl/pcde_back.sv =====
module pcde_back import pcde_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  rect_t       head,
  input  logic        fifo_empty,
  output logic        pop,
  output logic        store_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] read_colour,
  output logic        is_clear
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [23:0] colour_mem [DEPTH];
  logic        shown_mem  [DEPTH];

  bk_state_t   state, state_next;
  rect_t       cur;
  logic [9:0]  cx, cy;
  logic [31:0] s;
  logic [31:0] s_upd;
  logic [AW-1:0] clr_addr;
  logic [19:0] lin;
  logic [AW-1:0] pix_addr;
  logic        at_end;
  logic        issue;
  logic        load_out;

  logic          p1_valid;
  op_t           p1_op;
  logic [AW-1:0] p1_addr;
  logic [15:0]   p1_v;
  logic [23:0]   p1_colour;
  logic [23:0]   p1_light;
  logic          p2_valid;
  op_t           p2_op;
  logic [AW-1:0] p2_addr;
  logic [23:0]   p2_colour;
  logic [23:0]   p2_n [3];
  logic [23:0]   blend;

  logic [23:0] rd_colour;
  logic        rd_shown;

  assign lin      = {10'd0, cy} * 20'(MAX_WIDTH) + {10'd0, cx};
  assign pix_addr = lin[AW-1:0];
  assign at_end   = (cx == cur.x1) && (cy == cur.y1);
  assign s_upd    = s * LCG_MUL + LCG_ADD;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = BK_IDLE;
      BK_IDLE: begin
        if (!fifo_empty) begin
          if (head.empty) state_next = head.last ? BK_RESP : BK_IDLE;
          else if (head.op == OP_READ) state_next = BK_READ;
          else state_next = BK_RUN;
        end
      end
      BK_RUN:   if (at_end) state_next = BK_DRAIN;
      BK_DRAIN: if (!p1_valid && !p2_valid) state_next = cur.last ? BK_RESP : BK_IDLE;
      BK_READ:  state_next = BK_RESP;
      BK_RESP:  if (!out_valid || out_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = (state == BK_IDLE) && !fifo_empty;
    issue       = (state == BK_RUN);
    load_out    = (state == BK_RESP) && (!out_valid || out_ready);
    store_ready = (state != BK_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CLEAR;
      clr_addr <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      if (state == BK_CLEAR) clr_addr <= clr_addr + AW'(1);
      p1_valid <= issue;
      p2_valid <= p1_valid;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      cx  <= head.x0;
      cy  <= head.y0;
      s   <= (head.seed == 32'd0) ? 32'd1 : head.seed;
    end else if (issue) begin
      s <= s_upd;
      if (cx == cur.x1) begin
        cx <= cur.x0;
        cy <= cy + 10'd1;
      end else begin
        cx <= cx + 10'd1;
      end
    end
    p1_addr   <= pix_addr;
    p1_op     <= cur.op;
    p1_v      <= s_upd[23:8];
    p1_colour <= cur.colour;
    p1_light  <= cur.light;
    p2_addr   <= p1_addr;
    p2_op     <= p1_op;
    p2_colour <= p1_colour;
    for (int c = 0; c < 3; c++) begin
      p2_n[c] <= 24'(p1_colour[8*c +: 8]) * 24'(16'hFFFF - p1_v)
               + 24'(p1_light[8*c +: 8]) * 24'(p1_v) + 24'd32767;
    end
    if (load_out) begin
      if (cur.op == OP_READ) begin
        read_colour <= cur.empty ? 24'd0 : rd_colour;
        is_clear    <= cur.empty ? 1'b1 : !rd_shown;
      end else begin
        read_colour <= 24'd0;
        is_clear    <= 1'b0;
      end
    end
  end

  // Division by 65535 as (n + (n >> 16) + 1) >> 16, exact for these sums.
  always_comb begin
    logic [24:0] t;
    blend = '0;
    for (int c = 0; c < 3; c++) begin
      t = {1'b0, p2_n[c]} + {9'd0, p2_n[c][23:16]} + 25'd1;
      blend[8*c +: 8] = t[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_CLEAR) begin
      colour_mem[clr_addr] <= 24'd0;
      shown_mem[clr_addr]  <= 1'b1;
    end else if (p2_valid) begin
      shown_mem[p2_addr] <= (p2_op != OP_CLEAR);
      if (p2_op != OP_CLEAR) colour_mem[p2_addr] <= (p2_op == OP_NOISE) ? blend : p2_colour;
    end
    if (state == BK_READ) begin
      rd_colour <= colour_mem[pix_addr];
      rd_shown  <= shown_mem[pix_addr];
    end
  end

endmodule

// ===== rtl/pixel_canvas_draw_engine.sv =====
// Each command taken raises out_valid once, after its clipped pixels are written;
// a read answers from the store, and a fully clipped command answers without drawing.
// A box outline is drawn as its top, bottom, left and right edges, each clipped on its own.
// Throughput: one pixel per cycle while drawing, set by the single store write port.
// Reset: synchronous; a clearing pass over all MAX_WIDTH*MAX_HEIGHT pixels (4096 by default)
// makes every pixel black and shown, with in_ready low until it is done.
module pixel_canvas_draw_engine import pcde_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] extent_x,
  input  logic signed [15:0] extent_y,
  input  logic [23:0]        colour,
  input  logic [23:0]        colour_light,
  input  logic [31:0]        seed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        read_colour,
  output logic               is_clear,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  logic  store_ready;
  logic  full;
  logic  push;
  rect_t push_data;
  logic  pop;
  rect_t head;
  logic  fifo_empty;

  pcde_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .x_pos, .y_pos, .extent_x, .extent_y,
    .colour, .colour_light, .seed, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .store_ready, .full, .push, .push_data
  );

  pcde_fifo u_fifo (
    .clk, .rst, .push, .push_data, .full, .pop, .head, .empty(fifo_empty)
  );

  pcde_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst, .head, .fifo_empty, .pop, .store_ready, .out_valid, .out_ready,
    .read_colour, .is_clear
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !fifo_empty)
    else $error("queue read while empty");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while the previous one is still being split");

endmodule

// ===== test/pixel_canvas_draw_engine_tb.sv =====
module pixel_canvas_draw_engine_tb;
  import pcde_pkg::*;

  localparam int MAXW = 64;
  localparam int MAXH = 64;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [3:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [23:0]        colour;
    logic [23:0]        light;
    logic [31:0]        seed;
  } draw_cmd_t;

  typedef struct {
    logic [23:0] colour;
    logic        clear;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] cmd = '0;
  logic signed [15:0] x_pos = '0, y_pos = '0, extent_x = '0, extent_y = '0;
  logic [23:0] colour = '0, colour_light = '0;
  logic [31:0] seed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] read_colour;
  logic is_clear;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;

  pixel_canvas_draw_engine dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [23:0] canvas_colour [MAXW*MAXH];
  logic        canvas_shown [MAXW*MAXH];
  int unsigned model_w, model_h;

  draw_cmd_t pending_cmds[$];
  pixel_result_t expected_results[$];
  int errors = 0;
  bit quiet_phase = 0;
  bit in_acc = 0;
  int hold_off = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;

  function automatic int act_w();
    return model_w > MAXW ? MAXW : int'(model_w);
  endfunction

  function automatic int act_h();
    return model_h > MAXH ? MAXH : int'(model_h);
  endfunction

  function automatic bit on_canvas(int x, int y);
    return x >= 0 && y >= 0 && x < act_w() && y < act_h();
  endfunction

  function automatic void plot(int x, int y, logic [23:0] c);
    if (on_canvas(x, y)) begin
      canvas_colour[y*MAXW + x] = c;
      canvas_shown[y*MAXW + x] = 1'b1;
    end
  endfunction

  function automatic void span_h(int x0, int x1, int y, logic [23:0] c);
    int t;
    if (x1 < x0) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (y < 0 || y >= act_h()) return;
    if (x0 < 0) x0 = 0;
    if (x1 > act_w() - 1) x1 = act_w() - 1;
    for (int x = x0; x <= x1; x++) plot(x, y, c);
  endfunction

  function automatic void span_v(int x, int y0, int y1, logic [23:0] c);
    int t;
    if (y1 < y0) begin
      t = y0; y0 = y1; y1 = t;
    end
    if (x < 0 || x >= act_w()) return;
    if (y0 < 0) y0 = 0;
    if (y1 > act_h() - 1) y1 = act_h() - 1;
    for (int y = y0; y <= y1; y++) plot(x, y, c);
  endfunction

  function automatic void fill_area(int x, int y, int w, int h, logic [23:0] c);
    int x0, y0, x1, y1;
    x0 = x; y0 = y; x1 = x + w - 1; y1 = y + h - 1;
    if (w <= 0 || h <= 0) return;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > act_w() - 1) x1 = act_w() - 1;
    if (y1 > act_h() - 1) y1 = act_h() - 1;
    for (int r = y0; r <= y1; r++)
      for (int k = x0; k <= x1; k++) plot(k, r, c);
  endfunction

  function automatic logic [23:0] mix_colour(logic [23:0] d, logic [23:0] l, logic [15:0] v);
    logic [23:0] res;
    longint unsigned ch;
    for (int sh = 0; sh < 24; sh += 8) begin
      ch = (longint'(d[sh +: 8]) * (65535 - v) + longint'(l[sh +: 8]) * v + 32767) / 65535;
      res[sh +: 8] = ch[7:0];
    end
    return res;
  endfunction

  function automatic pixel_result_t apply_command(draw_cmd_t c);
    pixel_result_t r;
    int x, y, ex, ey;
    logic [31:0] s;
    x = int'(c.x); y = int'(c.y); ex = int'(c.ex); ey = int'(c.ey);
    r.colour = '0;
    r.clear = 1'b0;
    case (c.cmd)
      CMD_SET: plot(x, y, c.colour);
      CMD_CLEAR: if (on_canvas(x, y)) canvas_shown[y*MAXW + x] = 1'b0;
      CMD_READ: begin
        if (on_canvas(x, y)) begin
          r.colour = canvas_colour[y*MAXW + x];
          r.clear = !canvas_shown[y*MAXW + x];
        end else begin
          r.clear = 1'b1;
        end
      end
      CMD_HLINE: span_h(x, ex, y, c.colour);
      CMD_VLINE: span_v(x, y, ey, c.colour);
      CMD_BOX: begin
        if (ex > 0 && ey > 0) begin
          span_h(x, x + ex - 1, y, c.colour);
          span_h(x, x + ex - 1, y + ey - 1, c.colour);
          span_v(x, y, y + ey - 1, c.colour);
          span_v(x + ex - 1, y, y + ey - 1, c.colour);
        end
      end
      CMD_FILLBOX: fill_area(x, y, ex, ey, c.colour);
      CMD_FILL: fill_area(0, 0, act_w(), act_h(), c.colour);
      CMD_NOISE: begin
        s = (c.seed == 0) ? 32'd1 : c.seed;
        for (int yy = 0; yy < act_h(); yy++)
          for (int xx = 0; xx < act_w(); xx++) begin
            s = s * 32'd1664525 + 32'd1013904223;
            canvas_colour[yy*MAXW + xx] = mix_colour(c.colour, c.light, s[23:8]);
            canvas_shown[yy*MAXW + xx] = 1'b1;
          end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] near_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom);
      3: return $signed(16'($urandom_range(0, 20))) - 16'sd10;
      default: return 16'($urandom_range(0, 70));
    endcase
  endfunction

  function automatic logic signed [15:0] small_extent();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom);
      3: return $signed(16'($urandom_range(0, 4))) - 16'sd3;
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 18) c.cmd = CMD_SET;
    else if (pick < 26) c.cmd = CMD_CLEAR;
    else if (pick < 56) c.cmd = CMD_READ;
    else if (pick < 66) c.cmd = CMD_HLINE;
    else if (pick < 76) c.cmd = CMD_VLINE;
    else if (pick < 84) c.cmd = CMD_BOX;
    else if (pick < 93) c.cmd = CMD_FILLBOX;
    else if (pick < 95) c.cmd = CMD_FILL;
    else if (pick < 97) c.cmd = CMD_NOISE;
    else c.cmd = 4'($urandom_range(9, 15));
    c.x = near_coord();
    c.y = near_coord();
    c.colour = 24'($urandom);
    c.light = 24'($urandom);
    c.seed = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom;
    if (c.cmd == CMD_HLINE) begin
      c.ex = near_coord();
      c.ey = 16'($urandom);
    end else if (c.cmd == CMD_VLINE) begin
      c.ex = 16'($urandom);
      c.ey = near_coord();
    end else begin
      c.ex = small_extent();
      c.ey = small_extent();
    end
    return c;
  endfunction

  function automatic draw_cmd_t make_cmd(logic [3:0] op, int x, int y, int ex, int ey,
                                         logic [23:0] c, logic [23:0] l, logic [31:0] s);
    draw_cmd_t d;
    d.cmd = op; d.x = 16'(x); d.y = 16'(y); d.ex = 16'(ex); d.ey = 16'(ey);
    d.colour = c; d.light = l; d.seed = s;
    return d;
  endfunction

  function automatic void add_cmd(draw_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  // The model takes each item at the edge that accepts it.
  always @(posedge clk) begin
    in_acc <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready)
      expected_results = {expected_results, apply_command(pending_cmds.pop_front())};
  end

  // Sender: offers queued commands and holds each one until it is accepted.
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_acc)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(1, 10);
        in_valid <= 1'b0;
      end else begin
        cmd <= pending_cmds[0].cmd;
        x_pos <= pending_cmds[0].x;
        y_pos <= pending_cmds[0].y;
        extent_x <= pending_cmds[0].ex;
        extent_y <= pending_cmds[0].ey;
        colour <= pending_cmds[0].colour;
        colour_light <= pending_cmds[0].light;
        seed <= pending_cmds[0].seed;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver with random back-pressure and an optional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
      out_gap <= $urandom_range(1, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result colour=%h clear=%b", $time, read_colour, is_clear);
        errors++;
      end else begin
        if (read_colour !== expected_results[0].colour) begin
          $display("%0t: read_colour expected %h actual %h", $time,
                   expected_results[0].colour, read_colour);
          errors++;
        end
        if (is_clear !== expected_results[0].clear) begin
          $display("%0t: is_clear expected %b actual %b", $time,
                   expected_results[0].clear, is_clear);
          errors++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[pixel_canvas_draw_engine] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH_IDX) model_w = 32'(val);
    else model_h = 32'(val);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) add_cmd(random_cmd());
    wait_drained();
  endtask

  initial begin
    model_w = 64;
    model_h = 64;
    for (int i = 0; i < MAXW*MAXH; i++) begin
      canvas_colour[i] = '0;
      canvas_shown[i] = 1'b1;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_SET, 63, 63, 0, 0, 24'hFFFFFF, 0, 0));
    add_cmd(make_cmd(CMD_READ, 63, 63, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_SET, -32768, 32767, 0, 0, 24'h123456, 0, 0));
    add_cmd(make_cmd(CMD_READ, 64, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_READ, -1, -32768, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_CLEAR, 63, 63, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_READ, 63, 63, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_HLINE, 70, 5, -5, 0, 24'hA5A5A5, 0, 0));
    add_cmd(make_cmd(CMD_VLINE, 3, 32767, -32768, 0, 24'h5A5A5A, 0, 0));
    add_cmd(make_cmd(CMD_BOX, -2, -2, 8, 8, 24'h00FF00, 0, 0));
    add_cmd(make_cmd(CMD_BOX, 10, 10, 0, 5, 24'h0000FF, 0, 0));
    add_cmd(make_cmd(CMD_FILLBOX, 60, 60, 10, 10, 24'hFF0000, 0, 0));
    add_cmd(make_cmd(CMD_FILLBOX, 5, 5, -3, 4, 24'hFF00FF, 0, 0));
    add_cmd(make_cmd(CMD_READ, 5, 5, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_NOISE, 0, 0, 0, 0, 24'h000000, 24'hFFFFFF, 0));
    add_cmd(make_cmd(CMD_READ, 1, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_NOISE, 0, 0, 0, 0, 24'hFFFFFF, 24'h000000, 32'hFFFFFFFF));
    add_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 24'h808080, 0, 0));
    add_cmd(make_cmd(4'd15, 1, 1, 1, 1, 24'hFFFFFF, 24'hFFFFFF, 1));
    add_cmd(make_cmd(4'd9, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    write_reg(CFG_WIDTH_IDX, 7'd0);
    write_reg(CFG_HEIGHT_IDX, 7'd127);
    add_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 24'h111111, 0, 0));
    add_cmd(make_cmd(CMD_NOISE, 0, 0, 0, 0, 24'h111111, 24'h222222, 5));
    add_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    write_reg(CFG_WIDTH_IDX, 7'd13);
    write_reg(CFG_HEIGHT_IDX, 7'd9);
    run_random(150);

    // The receiver stalls for a long while so that the block backs up its input.
    hold_off = 600;
    write_reg(CFG_WIDTH_IDX, 7'd127);
    write_reg(CFG_HEIGHT_IDX, 7'd1);
    run_random(130);

    write_reg(CFG_WIDTH_IDX, 7'd64);
    write_reg(CFG_HEIGHT_IDX, 7'd64);
    run_random(200);

    quiet_phase = 1;
    write_reg(CFG_WIDTH_IDX, 7'd20);
    write_reg(CFG_HEIGHT_IDX, 7'd33);
    run_random(150);

    if (errors == 0)
      $display("[pixel_canvas_draw_engine] OK");
    else
      $display("[pixel_canvas_draw_engine] ERROR");
    $finish;
  end

endmodule
